// ----- hw/rtl/indexed_insert_remove_list_macros.svh -----
// Assertion helpers used by the list RTL.
`ifndef INDEXED_INSERT_REMOVE_LIST_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IIRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list assertion failed");

`endif

// ----- hw/rtl/iirl_pkg.sv -----
`timescale 1ns / 1ps
package iirl_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int LEN_W  = 5;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int IN_W   = 40;
	localparam int OUT_W  = 40;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic                write;
		logic                shift_up;
		logic                shift_down;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   data;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/iirl_cell.sv -----
`timescale 1ns / 1ps
module iirl_cell #(
	parameter int INDEX = 0
) (
	input  logic                       clk,
	input  iirl_pkg::cell_ctrl_t       ctrl,
	input  logic [iirl_pkg::DATA_W-1:0] left,
	input  logic [iirl_pkg::DATA_W-1:0] right,
	output logic [iirl_pkg::DATA_W-1:0] value,
	output logic [iirl_pkg::DATA_W-1:0] tap
);
	import iirl_pkg::*;

	localparam logic [31:0] IDX = 32'(INDEX);

	logic [DATA_W-1:0] value_q;
	logic [31:0]       pos_w;
	logic              at_pos;
	logic              past_pos;

	assign pos_w    = 32'(ctrl.position);
	assign at_pos   = (pos_w == IDX);
	assign past_pos = (IDX > pos_w);

	// A write overwrites the addressed cell; an insert also moves every later
	// cell up; a remove pulls the addressed cell and every later one down.
	always_ff @(posedge clk) begin
		if (ctrl.write && at_pos) begin
			value_q <= ctrl.data;
		end else if (ctrl.shift_up && past_pos) begin
			value_q <= left;
		end else if (ctrl.shift_down && (at_pos || past_pos)) begin
			value_q <= right;
		end
	end

	assign value = value_q;
	assign tap   = at_pos ? value_q : '0;

endmodule

// ----- hw/rtl/indexed_insert_remove_list.sv -----
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values kept in a row of cells.
// Each input beat reads, overwrites, inserts before, or removes at a position
// and yields one output beat with the value, the new length and a status.
// Every cell compares its own place with the position and shifts in the same
// cycle, so one beat is taken per clock; the result sits in an output
// register, and a new beat is accepted whenever that register is empty or is
// being drained. Positions are 5 bits wide, so only the first 32 entries can
// be addressed directly, and the reported length is the count modulo 32.
`include "indexed_insert_remove_list_macros.svh"
module indexed_insert_remove_list #(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [1:0] op, [6:2] position, [38:7] data_in, [39] zero
	input  logic [iirl_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [31:0] data_out, [36:32] length, [38:37] status, [39] zero
	output logic [iirl_pkg::OUT_W-1:0] m_tdata
);
	import iirl_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;
	localparam int NTAP  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

	logic                 accept;
	op_t                  op;
	logic [POS_W-1:0]     position;
	logic [DATA_W-1:0]    data_in;
	logic [OCC_W-1:0]     occ_q;
	logic [OCC_W-1:0]     occ_nxt;
	logic                 pos_lt;
	logic                 pos_le;
	logic                 full;
	status_t              status;
	logic [DATA_W-1:0]    rd_data;
	logic [DATA_W-1:0]    tap_or;
	cell_ctrl_t           ctrl;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	logic [DATA_W-1:0]    cell_val [CAPACITY];
	logic [DATA_W-1:0]    tap      [NTAP];

	assign op       = op_t'(s_tdata[1:0]);
	assign position = s_tdata[6:2];
	assign data_in  = s_tdata[38:7];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_lt = CMP_W'(position) <  CMP_W'(occ_q);
	assign pos_le = CMP_W'(position) <= CMP_W'(occ_q);
	assign full   = (occ_q == OCC_W'(CAPACITY));

	always_comb begin
		tap_or = '0;
		for (int i = 0; i < NTAP; i++) begin
			tap_or = tap_or | tap[i];
		end
	end

	always_comb begin
		status          = ST_OK;
		rd_data         = '0;
		occ_nxt         = occ_q;
		ctrl.write      = 1'b0;
		ctrl.shift_up   = 1'b0;
		ctrl.shift_down = 1'b0;
		ctrl.position   = position;
		ctrl.data       = data_in;
		unique case (op)
			OP_READ: begin
				if (!pos_lt) begin
					status = ST_RANGE;
				end else begin
					rd_data = tap_or;
				end
			end
			OP_WRITE: begin
				if (!pos_lt) begin
					status = ST_RANGE;
				end else begin
					ctrl.write = accept;
				end
			end
			OP_INSERT: begin
				// A bad position wins over a full list.
				if (!pos_le) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.write    = accept;
					ctrl.shift_up = accept;
					occ_nxt       = occ_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!pos_lt) begin
					status = ST_RANGE;
				end else begin
					rd_data         = tap_or;
					ctrl.shift_down = accept;
					occ_nxt         = occ_q - 1'b1;
				end
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [DATA_W-1:0] left;
			logic [DATA_W-1:0] right;
			if (g == 0) begin : g_head
				assign left = '0;
			end else begin : g_mid_l
				assign left = cell_val[g-1];
			end
			if (g == CAPACITY - 1) begin : g_tail
				assign right = '0;
			end else begin : g_mid_r
				assign right = cell_val[g+1];
			end
			if (g < NTAP) begin : g_tap
				iirl_cell #(.INDEX(g)) u_cell (
					.clk   (clk),
					.ctrl  (ctrl),
					.left  (left),
					.right (right),
					.value (cell_val[g]),
					.tap   (tap[g])
				);
			end else begin : g_notap
				iirl_cell #(.INDEX(g)) u_cell (
					.clk   (clk),
					.ctrl  (ctrl),
					.left  (left),
					.right (right),
					.value (cell_val[g]),
					.tap   ()
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q <= occ_nxt;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, status, LEN_W'(occ_nxt), rd_data};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`IIRL_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OCC_W'(CAPACITY))
	`IIRL_ASSERT_NEXT(a_insert_grows, clk, arst_n,
		accept && op == OP_INSERT && status == ST_OK,
		occ_q == OCC_W'($past(occ_q) + 1'b1))
	`IIRL_ASSERT_NEXT(a_error_keeps_len, clk, arst_n,
		accept && status != ST_OK, $stable(occ_q))
	`IIRL_ASSERT_NOW(a_error_zero_data, clk, arst_n,
		m_tvalid_q && m_tdata_q[38:37] != ST_OK, m_tdata_q[31:0] == '0)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import iirl_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int SCRIPT_ROWS = 23;
	localparam int PHASE_ITEMS = 285;

	typedef struct packed {
		status_t             st;
		logic [LEN_W-1:0]    count;
		logic [DATA_W-1:0]   value;
	} list_result_t;

	typedef struct packed {
		op_t                 op;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   data_in;
		logic [4:0]          reps;
		logic                typed;
		logic [DATA_W-1:0]   want_data;
		logic [LEN_W-1:0]    want_len;
		status_t             want_st;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	// Shadow copy of the list, advanced once per accepted request beat.
	logic [DATA_W-1:0]   shadow_vals [CAPACITY];
	int                  shadow_len = 0;
	list_result_t        awaited[$];

	int  send_idle_pct = 9;
	int  recv_idle_pct = 69;
	int  hold_asks = 0;
	int  mismatches = 0;
	int  requests_sent = 0;
	int  results_checked = 0;
	int  range_errors = 0;
	int  full_refusals = 0;
	int  peak_len = 0;

	indexed_insert_remove_list #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic list_result_t list_apply(input op_t op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		list_result_t r;
		r.value = '0;
		r.st = ST_OK;
		if (op == OP_INSERT) begin
			if (pos > shadow_len) begin
				r.st = ST_RANGE;
			end else if (shadow_len >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				for (int i = shadow_len; i > pos; i--)
					shadow_vals[i] = shadow_vals[i-1];
				shadow_vals[pos] = val;
				shadow_len++;
			end
		end else if (pos >= shadow_len) begin
			r.st = ST_RANGE;
		end else if (op == OP_READ) begin
			r.value = shadow_vals[pos];
		end else if (op == OP_WRITE) begin
			shadow_vals[pos] = val;
		end else begin
			r.value = shadow_vals[pos];
			for (int i = pos; i + 1 < shadow_len; i++)
				shadow_vals[i] = shadow_vals[i+1];
			shadow_len--;
		end
		r.count = shadow_len[LEN_W-1:0];
		return r;
	endfunction

	task automatic send_request(input op_t op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input logic typed, input list_result_t typed_res);
		list_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, val, pos, op};
		do @(posedge clk); while (!s_tready);
		predicted = list_apply(op, pos, val);
		awaited.push_back(typed ? typed_res : predicted);
		requests_sent++;
		if (predicted.st == ST_RANGE)
			range_errors++;
		if (predicted.st == ST_FULL)
			full_refusals++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaited.size() != 0);
	endtask

	// Receiver: checks every result beat and drives m_tready, including the long hold-off.
	initial begin
		list_result_t got;
		list_result_t want;
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = list_result_t'(m_tdata[38:0]);
				results_checked++;
				if (awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: data %h length %0d status %0d",
							got.value, got.count, got.st);
				end else begin
					want = awaited.pop_front();
					if (got.value !== want.value || got.count !== want.count
							|| got.st !== want.st) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected data %h length %0d ",
								"status %0d, got data %h length %0d status %0d"},
								want.value, want.count, want.st,
								got.value, got.count, got.st);
					end
				end
			end
			if (holds_done < hold_asks) begin
				holds_done++;
				hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no beat moves on either side for too long.
	initial begin
		int stalled;
		stalled = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				stalled = 0;
			else
				stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results still awaited",
					stalled, awaited.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		script_row_t script [SCRIPT_ROWS];
		list_result_t typed_res;
		op_t op;
		logic [POS_W-1:0] pos;
		logic [DATA_W-1:0] val;
		int roll;
		bit grow;

		script = '{
			'{OP_READ,   5'd0,  32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  ST_RANGE},
			'{OP_REMOVE, 5'd0,  32'h0,        5'd1,  1'b1, 32'h0,        5'd0,  ST_RANGE},
			'{OP_WRITE,  5'd0,  32'h5,        5'd1,  1'b1, 32'h0,        5'd0,  ST_RANGE},
			'{OP_INSERT, 5'd1,  32'h9,        5'd1,  1'b1, 32'h0,        5'd0,  ST_RANGE},
			'{OP_INSERT, 5'd0,  32'h7fffffff, 5'd1,  1'b1, 32'h0,        5'd1,  ST_OK},
			'{OP_INSERT, 5'd0,  32'h80000000, 5'd1,  1'b1, 32'h0,        5'd2,  ST_OK},
			'{OP_READ,   5'd0,  32'hffffffff, 5'd1,  1'b1, 32'h80000000, 5'd2,  ST_OK},
			'{OP_READ,   5'd1,  32'h0,        5'd1,  1'b1, 32'h7fffffff, 5'd2,  ST_OK},
			'{OP_READ,   5'd31, 32'h0,        5'd1,  1'b1, 32'h0,        5'd2,  ST_RANGE},
			'{OP_WRITE,  5'd1,  32'hffffffff, 5'd1,  1'b1, 32'h0,        5'd2,  ST_OK},
			'{OP_INSERT, 5'd2,  32'h1,        5'd1,  1'b0, 32'h0,        5'd0,  ST_OK},
			'{OP_REMOVE, 5'd0,  32'h0,        5'd1,  1'b0, 32'h0,        5'd0,  ST_OK},
			'{OP_INSERT, 5'd1,  32'ha5a5a5a5, 5'd14, 1'b0, 32'h0,        5'd0,  ST_OK},
			'{OP_INSERT, 5'd16, 32'h12345678, 5'd1,  1'b1, 32'h0,        5'd16, ST_FULL},
			'{OP_INSERT, 5'd0,  32'h12345678, 5'd1,  1'b1, 32'h0,        5'd16, ST_FULL},
			'{OP_INSERT, 5'd17, 32'h0,        5'd1,  1'b1, 32'h0,        5'd16, ST_RANGE},
			'{OP_INSERT, 5'd31, 32'h0,        5'd1,  1'b1, 32'h0,        5'd16, ST_RANGE},
			'{OP_READ,   5'd15, 32'h0,        5'd1,  1'b0, 32'h0,        5'd0,  ST_OK},
			'{OP_WRITE,  5'd15, 32'h0,        5'd1,  1'b0, 32'h0,        5'd0,  ST_OK},
			'{OP_REMOVE, 5'd15, 32'h0,        5'd1,  1'b0, 32'h0,        5'd0,  ST_OK},
			'{OP_REMOVE, 5'd0,  32'h0,        5'd1,  1'b0, 32'h0,        5'd0,  ST_OK},
			'{OP_READ,   5'd14, 32'h0,        5'd1,  1'b1, 32'h0,        5'd14, ST_RANGE},
			'{OP_REMOVE, 5'd7,  32'h0,        5'd1,  1'b0, 32'h0,        5'd0,  ST_OK}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			typed_res.value = script[r].want_data;
			typed_res.count = script[r].want_len;
			typed_res.st = script[r].want_st;
			for (int k = 0; k < script[r].reps; k++)
				send_request(script[r].op, script[r].position, script[r].data_in + k,
					script[r].typed, typed_res);
		end
		wait_drained();

		typed_res = '0;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 69 : 0;
			recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 9 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Alternate between stretches that fill the list and ones that empty it.
				grow = ((n / 64) % 2) == 0;
				roll = $urandom_range(99);
				if (grow)
					op = roll < 45 ? OP_INSERT : roll < 60 ? OP_REMOVE :
						roll < 80 ? OP_READ : OP_WRITE;
				else
					op = roll < 12 ? OP_INSERT : roll < 55 ? OP_REMOVE :
						roll < 78 ? OP_READ : OP_WRITE;
				if ($urandom_range(99) < 12)
					pos = POS_W'($urandom_range(31));
				else if (op == OP_INSERT)
					pos = POS_W'($urandom_range(shadow_len, 0));
				else if (shadow_len > 0)
					pos = POS_W'($urandom_range(shadow_len - 1, 0));
				else
					pos = POS_W'($urandom_range(31));
				if ($urandom_range(9) == 0)
					val = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
				else
					val = $urandom;
				send_request(op, pos, val, 1'b0, typed_res);
				if (phase == 2 && n == 40)
					hold_asks++;
				if (phase == 1 && n == 100)
					wait_drained();
			end
			wait_drained();
		end

		repeat (4) @(posedge clk);
		$display("%0d requests driven and %0d results checked under three stall patterns.",
			requests_sent, results_checked);
		$display("%0d out-of-range and %0d full-list responses; list length peaked at %0d.",
			range_errors, full_refusals, peak_len);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d result beats failed the check", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/iirl_pkg.sv
hw/rtl/iirl_cell.sv
hw/rtl/indexed_insert_remove_list.sv
tb/tb.sv
